/* rtl/core/pits_pkg.sv */
// Shared types, constants and codes for the point-in-triangle search block.
`timescale 1ns / 1ps

package pits_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_VERTICES_DEF  = 256;
  localparam int MAX_TRIANGLES_DEF = 256;
  localparam int COORD_WIDTH_DEF   = 16;

  // Width of the search count configuration word.
  localparam int CFG_W = 9;

  // Operation codes carried in the opcode field of an input word.
  localparam logic [1:0] OP_LOAD_VERTEX   = 2'd0;
  localparam logic [1:0] OP_LOAD_TRIANGLE = 2'd1;
  localparam logic [1:0] OP_QUERY         = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         slot;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [7:0]         corner_a;
    logic [7:0]         corner_b;
    logic [7:0]         corner_c;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [7:0] triangle_index;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_vtx;
    logic wr_tri;
    logic start;
    logic issue;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       count_zero;
    logic       all_issued;
    logic       hit;
    logic       miss_end;
    logic [7:0] hit_idx;
  } sts_t;

endpackage

/* rtl/core/pits_datapath.sv */
// Datapath: vertex and triangle stores, search counter and the containment pipeline.
`timescale 1ns / 1ps

module pits_datapath #(
  parameter int MAX_VERTICES  = pits_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = pits_pkg::MAX_TRIANGLES_DEF,
  parameter int COORD_WIDTH   = pits_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr,
  input  logic [pits_pkg::CFG_W-1:0] cfg_data,
  input  pits_pkg::in_word_t       in_word,
  input  pits_pkg::cmd_t           cmd,
  output pits_pkg::sts_t           sts
);

  // Only 256 slots can be named by the 8-bit slot and corner fields.
  localparam int VDEPTH = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
  localparam int TDEPTH = (MAX_TRIANGLES < 256) ? MAX_TRIANGLES : 256;
  localparam int CW     = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam int DW     = CW + 1;
  localparam int PW     = 2 * DW;
  localparam int XW     = PW + 1;
  localparam int VA_W   = $clog2(VDEPTH);
  localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int TCNT_W = $clog2(TDEPTH + 1);
  localparam int NSTG   = 5;

  function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] p,
                                                   input logic signed [CW-1:0] q);
    return DW'(p) - DW'(q);
  endfunction

  // True when s and d have strictly opposite signs.
  function automatic logic opposite(input logic signed [XW-1:0] s,
                                    input logic signed [XW-1:0] d);
    logic s_neg, s_pos, d_neg, d_pos;
    s_neg = s[XW-1];
    s_pos = !s[XW-1] && (s != '0);
    d_neg = d[XW-1];
    d_pos = !d[XW-1] && (d != '0);
    return (s_pos && d_neg) || (s_neg && d_pos);
  endfunction

  logic [TCNT_W-1:0]     tiu_r;
  logic [TCNT_W-1:0]     cnt_r;
  logic signed [CW-1:0]  px_r;
  logic signed [CW-1:0]  py_r;

  logic [23:0]           tri_mem [TDEPTH];
  logic signed [CW-1:0]  vx_mem  [3][VDEPTH];
  logic signed [CW-1:0]  vy_mem  [3][VDEPTH];

  logic [NSTG-1:0]       vld_r;
  logic [NSTG-1:0]       last_r;
  logic [TA_W-1:0]       tag_r [NSTG];

  logic [23:0]           tri_rd_r;
  logic [7:0]            corner [3];
  logic signed [CW-1:0]  vx_rd_r [3];
  logic signed [CW-1:0]  vy_rd_r [3];
  logic [2:0]            cin_r;
  logic signed [CW-1:0]  vx [3];
  logic signed [CW-1:0]  vy [3];

  logic signed [DW-1:0]  ex_r [3];
  logic signed [DW-1:0]  ey_r [3];
  logic signed [DW-1:0]  qx_r [3];
  logic signed [DW-1:0]  qy_r [3];

  logic signed [PW-1:0]  pa_r [3];
  logic signed [PW-1:0]  pb_r [3];
  logic signed [PW-1:0]  oa_r;
  logic signed [PW-1:0]  ob_r;

  logic signed [XW-1:0]  side [3];
  logic signed [XW-1:0]  orient;
  logic                  hit_nxt;
  logic                  hit_r;

  logic                  vtx_slot_ok;
  logic                  tri_slot_ok;
  logic                  issue_last;

  assign vtx_slot_ok = {1'b0, in_word.slot} < 9'(VDEPTH);
  assign tri_slot_ok = {1'b0, in_word.slot} < 9'(TDEPTH);
  assign issue_last  = TCNT_W'(cnt_r + 1'b1) == tiu_r;

  // Search count, saturated to the triangle store depth when written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiu_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_data > 9'(TDEPTH)) begin
        tiu_r <= TCNT_W'(TDEPTH);
      end else begin
        tiu_r <= TCNT_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r  <= in_word.x_coord[CW-1:0];
      py_r  <= in_word.y_coord[CW-1:0];
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= TCNT_W'(cnt_r + 1'b1);
    end
  end

  // Triangle store, read one slot per cycle at the search counter.
  always_ff @(posedge clk) begin
    if (cmd.wr_tri && tri_slot_ok) begin
      tri_mem[in_word.slot[TA_W-1:0]] <= {in_word.corner_c, in_word.corner_b,
                                          in_word.corner_a};
    end
    tri_rd_r <= tri_mem[cnt_r[TA_W-1:0]];
  end

  assign corner[0] = tri_rd_r[7:0];
  assign corner[1] = tri_rd_r[15:8];
  assign corner[2] = tri_rd_r[23:16];

  // One copy of the vertex store per corner so all three read together.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.wr_vtx && vtx_slot_ok) begin
        vx_mem[k][in_word.slot[VA_W-1:0]] <= in_word.x_coord[CW-1:0];
        vy_mem[k][in_word.slot[VA_W-1:0]] <= in_word.y_coord[CW-1:0];
      end
      vx_rd_r[k] <= vx_mem[k][corner[k][VA_W-1:0]];
      vy_rd_r[k] <= vy_mem[k][corner[k][VA_W-1:0]];
      cin_r[k]   <= {1'b0, corner[k]} < 9'(VDEPTH);
    end
  end

  // A corner beyond the vertex store stands for the origin.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vx[k] = cin_r[k] ? vx_rd_r[k] : '0;
      vy[k] = cin_r[k] ? vy_rd_r[k] : '0;
    end
  end

  // Edge vectors a->b, b->c, c->a and the point relative to each start.
  always_ff @(posedge clk) begin
    ex_r[0] <= sub_ext(vx[1], vx[0]);
    ey_r[0] <= sub_ext(vy[1], vy[0]);
    ex_r[1] <= sub_ext(vx[2], vx[1]);
    ey_r[1] <= sub_ext(vy[2], vy[1]);
    ex_r[2] <= sub_ext(vx[0], vx[2]);
    ey_r[2] <= sub_ext(vy[0], vy[2]);
    for (int k = 0; k < 3; k++) begin
      qx_r[k] <= sub_ext(px_r, vx[k]);
      qy_r[k] <= sub_ext(py_r, vy[k]);
    end
  end

  // Orientation crosses edge a->b with edge c->a negated, that is with edge a->c.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pa_r[k] <= PW'(ex_r[k]) * PW'(qy_r[k]);
      pb_r[k] <= PW'(ey_r[k]) * PW'(qx_r[k]);
    end
    oa_r <= PW'(ey_r[0]) * PW'(ex_r[2]);
    ob_r <= PW'(ex_r[0]) * PW'(ey_r[2]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side[k] = XW'(pa_r[k]) - XW'(pb_r[k]);
    end
    orient  = XW'(oa_r) - XW'(ob_r);
    hit_nxt = !(opposite(side[0], orient) || opposite(side[1], orient) ||
                opposite(side[2], orient));
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  // Valid, last and slot tags follow each triangle down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.flush) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], cmd.issue};
    end
    last_r   <= {last_r[NSTG-2:0], issue_last};
    tag_r[0] <= cnt_r[TA_W-1:0];
    for (int k = 1; k < NSTG; k++) begin
      tag_r[k] <= tag_r[k-1];
    end
  end

  assign sts.count_zero = tiu_r == '0;
  assign sts.all_issued = cnt_r == tiu_r;
  assign sts.hit        = vld_r[NSTG-1] && hit_r;
  assign sts.miss_end   = vld_r[NSTG-1] && last_r[NSTG-1] && !hit_r;
  assign sts.hit_idx    = 8'(tag_r[NSTG-1]);

endmodule

/* rtl/core/pits_ctrl.sv */
// Controller: sequences loads and queries and owns the result register.
`timescale 1ns / 1ps

module pits_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_opcode,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pits_pkg::out_word_t out_word,
  output pits_pkg::cmd_t      cmd,
  input  pits_pkg::sts_t      sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic                found_r, found_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  pits_pkg::out_word_t out_word_r, out_word_nxt;

  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            pits_pkg::OP_LOAD_VERTEX: begin
              cmd.wr_vtx = 1'b1;
            end
            pits_pkg::OP_LOAD_TRIANGLE: begin
              cmd.wr_tri = 1'b1;
            end
            pits_pkg::OP_QUERY: begin
              cmd.start = 1'b1;
              found_nxt = 1'b0;
              idx_nxt   = '0;
              state_nxt = sts.count_zero ? ST_RESULT : ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (sts.hit) begin
          cmd.flush = 1'b1;
          found_nxt = 1'b1;
          idx_nxt   = sts.hit_idx;
          state_nxt = ST_RESULT;
        end else if (sts.miss_end) begin
          cmd.flush = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          cmd.issue = !sts.all_issued;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.found          = found_r;
          out_word_nxt.triangle_index = idx_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    found_r    <= found_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/core/point_in_triangle_search.sv */
// Top level of the point-in-triangle search block: controller, datapath and checks.
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall   pits_pkg::in_word_t (load vertex, load triangle, query)
// out_     output     out_valid/out_stall pits_pkg::out_word_t (found, triangle_index)
// cfg_     input      cfg_valid/cfg_ready cfg_data: triangles searched per query
//
// A load word does not stall the input. A query over n triangles that finds nothing gives
// its result word once the last triangle leaves the pipeline, or without a search when n is
// zero; a hit on slot j gives it once that triangle leaves the pipeline. The search reads
// the triangle store one slot per cycle into a five-stage containment pipeline.
// Reset is synchronous and active low; the vertex and triangle stores are not cleared.
// A waiting result word does not hold up the next load or query word.

module point_in_triangle_search #(
  parameter int MAX_VERTICES  = pits_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = pits_pkg::MAX_TRIANGLES_DEF,
  parameter int COORD_WIDTH   = pits_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pits_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pits_pkg::out_word_t        out_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pits_pkg::CFG_W-1:0] cfg_data
);

  // The controller decides what each accepted word does and hands the
  // datapath one command per cycle; the datapath reports back when a
  // triangle has been found or when the last one has gone through.
  pits_pkg::cmd_t cmd;
  pits_pkg::sts_t sts;

  // The count register can always take a write; the user must write it only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  pits_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_word.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath keeps the stores, the point of the current query and the
  // pipeline that tests one triangle per cycle against it.
  pits_datapath #(
    .MAX_VERTICES  (MAX_VERTICES),
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts)
  );

`ifndef SYNTHESIS
  // No input word may be taken while triangles are still being issued.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.issue |-> in_stall)
    else $error("input accepted during a search");

  // A hit flushes the pipeline, so no second hit can follow directly.
  assert property (@(posedge clk) disable iff (!rst_n) sts.hit |=> !sts.hit)
    else $error("pipeline not flushed after a hit");

  // A new result word only appears after a query held the input off.
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a query in progress");
`endif

endmodule
